/* rtl/loop_trip_count_profiler_assert.svh */
// -----------------------------------------------------------------------------
// Loop trip count profiler assertion macros
// Shared concurrent assertion forms used by the profiler modules.
// -----------------------------------------------------------------------------
`ifndef LOOP_TRIP_COUNT_PROFILER_ASSERT_SVH
`define LOOP_TRIP_COUNT_PROFILER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must never be true.
`define LTCP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* rtl/ltcp_pkg.sv */
// -----------------------------------------------------------------------------
// Loop trip count profiler package
// Types and constants shared by the profiler modules.
// -----------------------------------------------------------------------------
package ltcp_pkg;

   localparam int LOOPS_DEFAULT = 256;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int TOTAL_WIDTH = 48;
   localparam int OUT_WIDTH = 32;
   localparam int LOOP_NUM_WIDTH = 8;
   localparam int CSR_WIDTH = 9;
   localparam logic [CSR_WIDTH-1:0] LOOPS_IN_USE_RESET = 9'd256;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_ENTRY = 1'b0,
      OP_ITER  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [LOOP_NUM_WIDTH-1:0] loop_number;
      logic                      out_of_range;
   } item_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

/* rtl/loop_trip_count_profiler.sv */
// -----------------------------------------------------------------------------
// Loop trip count profiler
// Keeps per-loop trip statistics and returns the updated entry for each event.
//
// An event word (opcode and loop number) is taken at a rising edge with start
// high and busy low. Opcode entry folds the finished invocation into the
// fewest, most and zero-trip statistics and starts a new invocation; opcode
// iteration bumps the running and total trip counts. All counters saturate.
// A loop number at or above loops_in_use, or beyond the table, returns a word
// with rsp_out_of_range set and all statistics zero, and changes nothing.
// Each event returns one word, shown for exactly one cycle with rsp_strobe;
// the receiver cannot stall. With the queue empty, an in-range word passes from
// the queue through the table read and the update state to the response
// registers; an out-of-range word goes from the queue straight to them. The back
// end reads a table entry and writes it back in the update state that follows,
// so it takes no event during an update; out-of-range events go one per cycle.
// A two-entry queue sits behind the front end; busy is high while it is full.
// After reset a clearing pass writes every entry to zero, one entry per cycle,
// with busy high; csr writes are taken at any time.
// -----------------------------------------------------------------------------
module loop_trip_count_profiler #(
   parameter int LOOPS = ltcp_pkg::LOOPS_DEFAULT,
   parameter int COUNT_WIDTH = ltcp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [ltcp_pkg::LOOP_NUM_WIDTH-1:0] req_loop_number,
   input  logic                                csr_wr_en,
   input  logic [ltcp_pkg::CSR_WIDTH-1:0]      csr_wr_data,
   output logic                                rsp_strobe,
   output logic                                rsp_out_of_range,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]      rsp_out_invocations,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]      rsp_out_current_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]      rsp_out_fewest_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]      rsp_out_most_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]      rsp_out_zero_trip_runs,
   output logic [ltcp_pkg::TOTAL_WIDTH-1:0]    rsp_out_total_trips
);

   logic                      push;
   ltcp_pkg::item_type        push_item;
   logic                      queue_full;
   logic                      q_valid;
   ltcp_pkg::item_type        q_item;
   logic                      q_pop;
   ltcp_pkg::back_status_type back_status;

   ltcp_front #(
      .LOOPS (LOOPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_loop_number (req_loop_number),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .queue_full      (queue_full),
      .back_status     (back_status),
      .push            (push),
      .push_item       (push_item)
   );

   ltcp_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item),
      .full      (queue_full)
   );

   ltcp_back #(
      .LOOPS       (LOOPS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_item                 (q_item),
      .q_pop                  (q_pop),
      .status                 (back_status),
      .rsp_strobe             (rsp_strobe),
      .rsp_out_of_range       (rsp_out_of_range),
      .rsp_out_invocations    (rsp_out_invocations),
      .rsp_out_current_trips  (rsp_out_current_trips),
      .rsp_out_fewest_trips   (rsp_out_fewest_trips),
      .rsp_out_most_trips     (rsp_out_most_trips),
      .rsp_out_zero_trip_runs (rsp_out_zero_trip_runs),
      .rsp_out_total_trips    (rsp_out_total_trips)
   );

endmodule

/* rtl/ltcp_ram.sv */
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module ltcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ltcp_fifo.sv */
// -----------------------------------------------------------------------------
// Loop trip count profiler event queue
// Short queue of classified events between the front and the back.
// -----------------------------------------------------------------------------
`include "loop_trip_count_profiler_assert.svh"

module ltcp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ltcp_pkg::item_type push_item,
   input  logic              pop,
   output logic              pop_valid,
   output ltcp_pkg::item_type pop_item,
   output logic              full
);

   localparam int DEPTH = ltcp_pkg::QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);

   ltcp_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNTW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNTW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign full = (count_ff == FULL_COUNT);

   `LTCP_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && full,
      "Event pushed into a full queue.")

endmodule

/* rtl/ltcp_front.sv */
// -----------------------------------------------------------------------------
// Loop trip count profiler front end
// Accepts events, holds the loops-in-use register and flags out-of-range loops.
// -----------------------------------------------------------------------------
module ltcp_front #(
   parameter int LOOPS = ltcp_pkg::LOOPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [ltcp_pkg::LOOP_NUM_WIDTH-1:0] req_loop_number,
   input  logic                                csr_wr_en,
   input  logic [ltcp_pkg::CSR_WIDTH-1:0]      csr_wr_data,
   input  logic                                queue_full,
   input  ltcp_pkg::back_status_type           back_status,
   output logic                                push,
   output ltcp_pkg::item_type                  push_item
);

   localparam logic [16:0] LOOPS_LIMIT = 17'(LOOPS);

   logic [ltcp_pkg::CSR_WIDTH-1:0] loops_in_use_ff, loops_in_use_in;

   always_comb begin
      loops_in_use_in = loops_in_use_ff;
      if (csr_wr_en) begin
         loops_in_use_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loops_in_use_ff <= ltcp_pkg::LOOPS_IN_USE_RESET;
      end else begin
         loops_in_use_ff <= loops_in_use_in;
      end
   end

   always_comb begin
      busy = queue_full || back_status.clearing;
      push = start && !busy;
      push_item.opcode = ltcp_pkg::opcode_type'(req_opcode);
      push_item.loop_number = req_loop_number;
      push_item.out_of_range =
         (ltcp_pkg::CSR_WIDTH'(req_loop_number) >= loops_in_use_ff) ||
         (17'(req_loop_number) >= LOOPS_LIMIT);
   end

endmodule

/* rtl/ltcp_back.sv */
// -----------------------------------------------------------------------------
// Loop trip count profiler back end
// Clears the statistics table after reset and applies queued events to it.
// -----------------------------------------------------------------------------
`include "loop_trip_count_profiler_assert.svh"

module ltcp_back #(
   parameter int LOOPS = ltcp_pkg::LOOPS_DEFAULT,
   parameter int COUNT_WIDTH = ltcp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  ltcp_pkg::item_type               q_item,
   output logic                             q_pop,
   output ltcp_pkg::back_status_type        status,
   output logic                             rsp_strobe,
   output logic                             rsp_out_of_range,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]   rsp_out_invocations,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]   rsp_out_current_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]   rsp_out_fewest_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]   rsp_out_most_trips,
   output logic [ltcp_pkg::OUT_WIDTH-1:0]   rsp_out_zero_trip_runs,
   output logic [ltcp_pkg::TOTAL_WIDTH-1:0] rsp_out_total_trips
);

   localparam int AW = (LOOPS > 1) ? $clog2(LOOPS) : 1;
   localparam int CW = COUNT_WIDTH;
   localparam int TW = ltcp_pkg::TOTAL_WIDTH;
   localparam int OW = ltcp_pkg::OUT_WIDTH;
   localparam int EW = 5 * CW + TW;
   localparam int INV_LO = 0;
   localparam int CUR_LO = CW;
   localparam int FEW_LO = 2 * CW;
   localparam int MOST_LO = 3 * CW;
   localparam int ZERO_LO = 4 * CW;
   localparam int TOT_LO = 5 * CW;
   localparam logic [AW-1:0] LAST_ADDR = AW'(LOOPS - 1);
   localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
   localparam logic [TW-1:0] TOT_MAX = {TW{1'b1}};
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   ltcp_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   ltcp_pkg::opcode_type  cur_op_ff, cur_op_in;
   logic [AW-1:0]         cur_idx_ff, cur_idx_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   logic [CW-1:0] old_inv, old_cur, old_few, old_most, old_zero;
   logic [TW-1:0] old_tot;
   logic [CW-1:0] new_inv, new_cur, new_few, new_most, new_zero;
   logic [TW-1:0] new_tot;
   logic [EW-1:0] new_entry;

   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_oor_ff, rsp_oor_in;
   logic [OW-1:0] rsp_inv_ff, rsp_inv_in;
   logic [OW-1:0] rsp_cur_ff, rsp_cur_in;
   logic [OW-1:0] rsp_few_ff, rsp_few_in;
   logic [OW-1:0] rsp_most_ff, rsp_most_in;
   logic [OW-1:0] rsp_zero_ff, rsp_zero_in;
   logic [TW-1:0] rsp_tot_ff, rsp_tot_in;

   ltcp_ram #(
      .WIDTH (EW),
      .DEPTH (LOOPS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltcp_pkg::BK_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ltcp_pkg::BK_IDLE;
            end
         end
         ltcp_pkg::BK_IDLE: begin
            if (q_valid && !q_item.out_of_range) begin
               state_in = ltcp_pkg::BK_UPDATE;
            end
         end
         ltcp_pkg::BK_UPDATE: begin
            state_in = ltcp_pkg::BK_IDLE;
         end
         default: begin
            state_in = ltcp_pkg::BK_CLEAR;
         end
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = cur_idx_ff;
      ram_wr_data = new_entry;
      status.clearing = 1'b0;
      case (state_ff)
         ltcp_pkg::BK_CLEAR: begin
            status.clearing = 1'b1;
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
         end
         ltcp_pkg::BK_IDLE: begin
            q_pop = q_valid;
            ram_rd_en = q_valid && !q_item.out_of_range;
         end
         ltcp_pkg::BK_UPDATE: begin
            ram_wr_en = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   assign ram_rd_addr = AW'(q_item.loop_number);

   always_comb begin
      old_inv = ram_rd_data[INV_LO +: CW];
      old_cur = ram_rd_data[CUR_LO +: CW];
      old_few = ram_rd_data[FEW_LO +: CW];
      old_most = ram_rd_data[MOST_LO +: CW];
      old_zero = ram_rd_data[ZERO_LO +: CW];
      old_tot = ram_rd_data[TOT_LO +: TW];
      new_inv = old_inv;
      new_cur = old_cur;
      new_few = old_few;
      new_most = old_most;
      new_zero = old_zero;
      new_tot = old_tot;
      if (cur_op_ff == ltcp_pkg::OP_ENTRY) begin
         if (old_inv == CNT_ONE) begin
            new_few = old_cur;
            new_most = old_cur;
         end else if (old_inv != '0) begin
            if (old_cur < old_few) begin
               new_few = old_cur;
            end
            if (old_cur > old_most) begin
               new_most = old_cur;
            end
         end
         if (old_inv != '0 && old_cur == '0 && old_zero != CNT_MAX) begin
            new_zero = CW'(old_zero + 1'b1);
         end
         if (old_inv != CNT_MAX) begin
            new_inv = CW'(old_inv + 1'b1);
         end
         new_cur = '0;
      end else begin
         if (old_cur != CNT_MAX) begin
            new_cur = CW'(old_cur + 1'b1);
         end
         if (old_tot != TOT_MAX) begin
            new_tot = TW'(old_tot + 1'b1);
         end
      end
      new_entry = {new_tot, new_zero, new_most, new_few, new_cur, new_inv};
   end

   always_comb begin
      logic [63:0] inv_wide, cur_wide, few_wide, most_wide, zero_wide;
      inv_wide = 64'(new_inv);
      cur_wide = 64'(new_cur);
      few_wide = 64'(new_few);
      most_wide = 64'(new_most);
      zero_wide = 64'(new_zero);
      clr_addr_in = clr_addr_ff;
      if (state_ff == ltcp_pkg::BK_CLEAR) begin
         clr_addr_in = AW'(clr_addr_ff + 1'b1);
      end
      cur_op_in = cur_op_ff;
      cur_idx_in = cur_idx_ff;
      if (q_pop) begin
         cur_op_in = q_item.opcode;
         cur_idx_in = AW'(q_item.loop_number);
      end
      rsp_strobe_in = 1'b0;
      rsp_oor_in = rsp_oor_ff;
      rsp_inv_in = rsp_inv_ff;
      rsp_cur_in = rsp_cur_ff;
      rsp_few_in = rsp_few_ff;
      rsp_most_in = rsp_most_ff;
      rsp_zero_in = rsp_zero_ff;
      rsp_tot_in = rsp_tot_ff;
      if (q_pop && q_item.out_of_range) begin
         rsp_strobe_in = 1'b1;
         rsp_oor_in = 1'b1;
         rsp_inv_in = '0;
         rsp_cur_in = '0;
         rsp_few_in = '0;
         rsp_most_in = '0;
         rsp_zero_in = '0;
         rsp_tot_in = '0;
      end else if (state_ff == ltcp_pkg::BK_UPDATE) begin
         rsp_strobe_in = 1'b1;
         rsp_oor_in = 1'b0;
         rsp_inv_in = inv_wide[OW-1:0];
         rsp_cur_in = cur_wide[OW-1:0];
         rsp_few_in = few_wide[OW-1:0];
         rsp_most_in = most_wide[OW-1:0];
         rsp_zero_in = zero_wide[OW-1:0];
         rsp_tot_in = new_tot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltcp_pkg::BK_CLEAR;
         clr_addr_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_op_ff <= cur_op_in;
      cur_idx_ff <= cur_idx_in;
      rsp_oor_ff <= rsp_oor_in;
      rsp_inv_ff <= rsp_inv_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_few_ff <= rsp_few_in;
      rsp_most_ff <= rsp_most_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_tot_ff <= rsp_tot_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_out_invocations = rsp_inv_ff;
   assign rsp_out_current_trips = rsp_cur_ff;
   assign rsp_out_fewest_trips = rsp_few_ff;
   assign rsp_out_most_trips = rsp_most_ff;
   assign rsp_out_zero_trip_runs = rsp_zero_ff;
   assign rsp_out_total_trips = rsp_tot_ff;

   `LTCP_ASSERT_NEXT(a_read_then_update, clock, reset, ram_rd_en,
      state_ff == ltcp_pkg::BK_UPDATE, "Table read not followed by an update.")
   `LTCP_ASSERT_IMPLY(a_no_rsp_while_clearing, clock, reset,
      state_ff == ltcp_pkg::BK_CLEAR, !rsp_strobe_ff,
      "Word delivered during the clearing pass.")
   `LTCP_ASSERT_IMPLY(a_oor_rsp_zero, clock, reset, rsp_strobe_ff && rsp_oor_ff,
      rsp_inv_ff == '0 && rsp_cur_ff == '0 && rsp_tot_ff == '0 && rsp_zero_ff == '0,
      "Out-of-range word carries nonzero statistics.")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Loop trip count profiler testbench
// Sends loop entry and iteration events through the start/busy handshake and
// checks every returned word against a pinned word or a predictor keeping its
// own copy of the per-loop statistics and of loops_in_use. A directed table
// opens the run; random phases with varied loops_in_use and idling follow.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ltcp_pkg::*;

   localparam int EVENT_TARGET = 1900;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES = 12;
   localparam int HOT_LOOPS = 8;

   typedef struct packed {
      logic        oor;
      logic [31:0] invocations;
      logic [31:0] current;
      logic [31:0] fewest;
      logic [31:0] most;
      logic [31:0] zero_runs;
      logic [47:0] total;
   } profile_word_type;

   typedef enum logic {
      ROW_EVENT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      opcode_type       op;
      logic [7:0]       loop;
      logic [8:0]       csr_value;
      logic             pinned;
      profile_word_type word;
   } plan_row_type;

   localparam profile_word_type NO_WORD = '0;
   localparam profile_word_type OOR_WORD = '{oor: 1'b1, default: '0};

   plan_row_type plan [27] = '{
      '{ROW_EVENT, OP_ITER,  8'd0,   9'd0,   1'b1, '{1'b0, 0, 1, 0, 0, 0, 1}},
      '{ROW_EVENT, OP_ENTRY, 8'd0,   9'd0,   1'b1, '{1'b0, 1, 0, 0, 0, 0, 1}},
      '{ROW_EVENT, OP_ENTRY, 8'd0,   9'd0,   1'b1, '{1'b0, 2, 0, 0, 0, 1, 1}},
      '{ROW_EVENT, OP_ITER,  8'd0,   9'd0,   1'b1, '{1'b0, 2, 1, 0, 0, 1, 2}},
      '{ROW_EVENT, OP_ITER,  8'd0,   9'd0,   1'b1, '{1'b0, 2, 2, 0, 0, 1, 3}},
      '{ROW_EVENT, OP_ENTRY, 8'd0,   9'd0,   1'b1, '{1'b0, 3, 0, 0, 2, 1, 3}},
      '{ROW_EVENT, OP_ITER,  8'd255, 9'd0,   1'b1, '{1'b0, 0, 1, 0, 0, 0, 1}},
      '{ROW_EVENT, OP_ENTRY, 8'd255, 9'd0,   1'b1, '{1'b0, 1, 0, 0, 0, 0, 1}},
      '{ROW_EVENT, OP_ITER,  8'd255, 9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd255, 9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd255, 9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd255, 9'd0,   1'b0, NO_WORD},
      '{ROW_CSR,   OP_ENTRY, 8'd0,   9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd0,   9'd0,   1'b1, OOR_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd255, 9'd0,   1'b1, OOR_WORD},
      '{ROW_CSR,   OP_ENTRY, 8'd0,   9'd1,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd0,   9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd1,   9'd0,   1'b1, OOR_WORD},
      '{ROW_CSR,   OP_ENTRY, 8'd0,   9'd511, 1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd255, 9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd170, 9'd0,   1'b0, NO_WORD},
      '{ROW_CSR,   OP_ENTRY, 8'd0,   9'd255, 1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd255, 9'd0,   1'b1, OOR_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd254, 9'd0,   1'b0, NO_WORD},
      '{ROW_EVENT, OP_ITER,  8'd85,  9'd0,   1'b0, NO_WORD},
      '{ROW_CSR,   OP_ENTRY, 8'd0,   9'd256, 1'b0, NO_WORD},
      '{ROW_EVENT, OP_ENTRY, 8'd0,   9'd0,   1'b0, NO_WORD}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   opcode_type                req_opcode = OP_ENTRY;
   logic [LOOP_NUM_WIDTH-1:0] req_loop_number = '0;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_WIDTH-1:0]      csr_wr_data = '0;
   logic                      rsp_strobe;
   logic                      rsp_out_of_range;
   logic [OUT_WIDTH-1:0]      rsp_out_invocations;
   logic [OUT_WIDTH-1:0]      rsp_out_current_trips;
   logic [OUT_WIDTH-1:0]      rsp_out_fewest_trips;
   logic [OUT_WIDTH-1:0]      rsp_out_most_trips;
   logic [OUT_WIDTH-1:0]      rsp_out_zero_trip_runs;
   logic [TOTAL_WIDTH-1:0]    rsp_out_total_trips;

   logic [31:0]       visits [LOOPS_DEFAULT];
   logic [31:0]       trips_now [LOOPS_DEFAULT];
   logic [31:0]       trips_min [LOOPS_DEFAULT];
   logic [31:0]       trips_max [LOOPS_DEFAULT];
   logic [31:0]       idle_runs [LOOPS_DEFAULT];
   logic [47:0]       trips_sum [LOOPS_DEFAULT];
   logic [8:0]        loops_limit;
   profile_word_type  pending_words [$];
   logic              word_pinned = 1'b0;
   profile_word_type  pinned_word = '0;
   bit                idling_on = 1'b1;
   int unsigned       mismatches = 0;
   int unsigned       quiet_cycles = 0;
   bit                progress;
   profile_word_type  want;
   profile_word_type  got;

   loop_trip_count_profiler dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_opcode             (req_opcode),
      .req_loop_number        (req_loop_number),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .rsp_strobe             (rsp_strobe),
      .rsp_out_of_range       (rsp_out_of_range),
      .rsp_out_invocations    (rsp_out_invocations),
      .rsp_out_current_trips  (rsp_out_current_trips),
      .rsp_out_fewest_trips   (rsp_out_fewest_trips),
      .rsp_out_most_trips     (rsp_out_most_trips),
      .rsp_out_zero_trip_runs (rsp_out_zero_trip_runs),
      .rsp_out_total_trips    (rsp_out_total_trips)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] bump32(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic profile_word_type fold_event(opcode_type op, logic [7:0] loop);
      profile_word_type w;
      logic [31:0]      finished;
      w = '0;
      if ({1'b0, loop} >= loops_limit || int'(loop) >= LOOPS_DEFAULT) begin
         w.oor = 1'b1;
         return w;
      end
      if (op == OP_ENTRY) begin
         finished = trips_now[loop];
         if (visits[loop] == 32'd1) begin
            trips_min[loop] = finished;
            trips_max[loop] = finished;
         end else if (visits[loop] != 32'd0) begin
            if (finished < trips_min[loop]) trips_min[loop] = finished;
            if (finished > trips_max[loop]) trips_max[loop] = finished;
         end
         if (visits[loop] != 32'd0 && finished == 32'd0)
            idle_runs[loop] = bump32(idle_runs[loop]);
         visits[loop] = bump32(visits[loop]);
         trips_now[loop] = '0;
      end else begin
         trips_now[loop] = bump32(trips_now[loop]);
         if (trips_sum[loop] != '1) trips_sum[loop] = trips_sum[loop] + 48'd1;
      end
      w.invocations = visits[loop];
      w.current = trips_now[loop];
      w.fewest = trips_min[loop];
      w.most = trips_max[loop];
      w.zero_runs = idle_runs[loop];
      w.total = trips_sum[loop];
      return w;
   endfunction

   task automatic check_field(string name, logic [47:0] exp_val, logic [47:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOOPS_DEFAULT; i++) begin
            visits[i] = '0;
            trips_now[i] = '0;
            trips_min[i] = '0;
            trips_max[i] = '0;
            idle_runs[i] = '0;
            trips_sum[i] = '0;
         end
         loops_limit = LOOPS_IN_USE_RESET;
         pending_words.delete();
         quiet_cycles = 0;
      end else begin
         progress = 1'b0;
         if (csr_wr_en) loops_limit = csr_wr_data;
         if (start && !busy) begin
            want = fold_event(req_opcode, req_loop_number);
            pending_words.push_back(word_pinned ? pinned_word : want);
            progress = 1'b1;
         end
         if (rsp_strobe) begin
            progress = 1'b1;
            got = '{rsp_out_of_range, rsp_out_invocations, rsp_out_current_trips,
                    rsp_out_fewest_trips, rsp_out_most_trips, rsp_out_zero_trip_runs,
                    rsp_out_total_trips};
            if (pending_words.size() == 0) begin
               mismatches++;
               $display("%0t: word expected none, got %0h", $time, got);
            end else begin
               want = pending_words.pop_front();
               check_field("out_of_range", 48'(want.oor), 48'(got.oor));
               check_field("invocations", 48'(want.invocations), 48'(got.invocations));
               check_field("current_trips", 48'(want.current), 48'(got.current));
               check_field("fewest_trips", 48'(want.fewest), 48'(got.fewest));
               check_field("most_trips", 48'(want.most), 48'(got.most));
               check_field("zero_trip_runs", 48'(want.zero_runs), 48'(got.zero_runs));
               check_field("total_trips", want.total, got.total);
            end
         end
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_event(opcode_type op, logic [7:0] loop, logic pinned,
                             profile_word_type word);
      if (idling_on && $urandom_range(0, 99) < 25) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_loop_number = loop;
      word_pinned = pinned;
      pinned_word = word;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_loops_in_use(logic [8:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int unsigned in_range_sent;
      int unsigned phase;
      int unsigned phase_items;
      int unsigned entry_pct;
      int unsigned span;
      logic [8:0]  limit;
      logic [7:0]  hot [HOT_LOOPS];
      logic [7:0]  loop;
      opcode_type  op;

      in_range_sent = 0;
      phase = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_loops_in_use(plan[i].csr_value);
         end else begin
            send_event(plan[i].op, plan[i].loop, plan[i].pinned, plan[i].word);
         end
      end

      while (in_range_sent < EVENT_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: limit = 9'd256;
            4: limit = 9'd511;
            5: limit = 9'd255;
            6: limit = 9'($urandom_range(1, 16));
            7: limit = 9'($urandom_range(1, 255));
            8: limit = 9'd0;
            default: limit = 9'($urandom_range(0, 511));
         endcase
         drain();
         write_loops_in_use(limit);
         span = (limit > 9'd256) ? 256 : int'(limit);
         foreach (hot[k])
            hot[k] = (span > 0 && $urandom_range(0, 99) < 90) ?
                     8'($urandom_range(0, span - 1)) : 8'($urandom_range(0, 255));
         idling_on = (phase % 4 != 1);
         entry_pct = $urandom_range(10, 45);
         phase_items = (span == 0) ? 20 : $urandom_range(100, 250);
         repeat (phase_items) begin
            if ($urandom_range(0, 99) < 75) begin
               loop = hot[$urandom_range(0, HOT_LOOPS - 1)];
               op = ($urandom_range(0, 99) < entry_pct) ? OP_ENTRY : OP_ITER;
            end else begin
               loop = 8'($urandom_range(0, 255));
               op = opcode_type'($urandom_range(0, 1));
            end
            if ({1'b0, loop} < limit) in_range_sent++;
            send_event(op, loop, 1'b0, NO_WORD);
         end
         phase++;
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
